@@ rtl/core/transform_matrix_composer_macros.svh @@
// Assertion macros used by the RTL of the transform matrix composer.
// Define NO_ASSERTIONS to compile every check away.
`ifndef TRANSFORM_MATRIX_COMPOSER_MACROS_SVH
`define TRANSFORM_MATRIX_COMPOSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that is switched off while reset is held
`define TMC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("transform_matrix_composer: assertion failed");

// Check that also holds while reset is held
`define TMC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("transform_matrix_composer: assertion failed");

`else

`define TMC_ASSERT(lbl, clk, rst, prop)
`define TMC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/core/tmc_pkg.sv @@
`default_nettype none

package tmc_pkg;

  // Element format: Q16.16 two's complement
  localparam int ELEM_W    = 32;
  localparam int FRAC_BITS = 16;

  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 4;
  localparam int ROW_W    = $clog2(NUM_ROWS);
  localparam int NUM_MUL  = 4;

  // Coefficient carries one extra bit so that the negated sine never wraps
  localparam int COEF_W = ELEM_W + 1;
  localparam int PROD_W = ELEM_W + COEF_W;
  localparam int SHP_W  = PROD_W - FRAC_BITS;
  localparam int SUM_W  = SHP_W + 1;

  localparam int KIND_W     = 3;
  localparam int IN_DATA_W  = 3 * ELEM_W;
  localparam int OUT_DATA_W = NUM_COLS * ELEM_W;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SHP_W-1:0]  shp_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [ROW_W-1:0]         row_idx_t;

  localparam row_idx_t ROW_FIRST = row_idx_t'(0);
  localparam row_idx_t ROW_LAST  = row_idx_t'(NUM_ROWS - 1);

  localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam elem_t ELEM_ONE = elem_t'(64'sd1 << FRAC_BITS);
  localparam elem_t ELEM_ZERO = '0;

  // Command codes
  typedef enum logic [KIND_W-1:0] {
    KIND_TRANSLATE = 3'd0,
    KIND_ZOOM      = 3'd1,
    KIND_ROT_X     = 3'd2,
    KIND_ROT_Y     = 3'd3,
    KIND_ROT_Z     = 3'd4
  } kind_t;

endpackage

`default_nettype wire

@@ rtl/core/transform_matrix_composer.sv @@
// Transform matrix composer.
// Holds a 4x4 Q16.16 matrix, identity after reset, and multiplies it on the
// right by a translate, zoom or rotate matrix for every request on the slave
// stream (s_tuser = command, s_tdata = x, y, z parameters). After each
// request the four rows of the updated matrix leave on the master stream,
// row 0 first, m_tuser = row number, m_tlast on row 3. Codes 5 to 7 leave
// the matrix as it is but still send the four rows.
// Pipeline: command register, product stage register, output register;
// rows leave in order, one per clock while m_tready does not stall, from
// the single row datapath (four 32x33 multipliers, then add and saturate)
// that handles one row per cycle. The next request is taken while the last
// row of the current one is still in flight.
// Reset: the matrix returns to identity and all pending rows are dropped.
// Stall: when m_tready is low the output register holds, the row pipeline
// freezes and s_tready drops once the current request has entered it.
`default_nettype none

`include "transform_matrix_composer_macros.svh"

module transform_matrix_composer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [31:0] param_x, [63:32] param_y, [95:64] param_z
  input  logic [tmc_pkg::IN_DATA_W-1:0]    s_tdata,
  // [2:0] kind
  input  logic [tmc_pkg::KIND_W-1:0]       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [31:0] elem0, [63:32] elem1, [95:64] elem2, [127:96] elem3
  output logic [tmc_pkg::OUT_DATA_W-1:0]   m_tdata,
  // [1:0] row_index
  output logic [tmc_pkg::ROW_W-1:0]        m_tuser,
  output logic                             m_tlast
);

  import tmc_pkg::*;

  function automatic elem_t sat_elem(sum_t v);
    elem_t r;
    if (v > sum_t'(ELEM_MAX)) begin
      r = ELEM_MAX;
    end else if (v < sum_t'(ELEM_MIN)) begin
      r = ELEM_MIN;
    end else begin
      r = elem_t'(v);
    end
    return r;
  endfunction

  // Matrix state
  elem_t mat [NUM_ROWS][NUM_COLS];

  // Command register, walks the rows
  logic              cmd_valid;
  logic [KIND_W-1:0] kind;
  elem_t             param_x;
  elem_t             param_y;
  elem_t             param_z;
  row_idx_t          row;

  // Product stage
  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  row_idx_t          s1_row;
  elem_t             s1_m [NUM_COLS];
  shp_t              s1_p [NUM_MUL];

  // Output register
  elem_t out_e [NUM_COLS];

  logic adv;
  logic s0_go;
  logic in_take;

  elem_t rd [NUM_COLS];
  elem_t mul_a [NUM_MUL];
  coef_t mul_b [NUM_MUL];
  shp_t  shp [NUM_MUL];
  coef_t c_x;
  coef_t c_y;
  coef_t c_ny;
  coef_t c_z;
  elem_t new_row [NUM_COLS];

  // Handshake and pipeline enables
  assign adv      = !m_tvalid || m_tready;
  assign s0_go    = cmd_valid && adv;
  assign s_tready = !cmd_valid || (adv && (row == ROW_LAST));
  assign in_take  = s_tvalid && s_tready;

  // Command register and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      row       <= ROW_FIRST;
    end else if (in_take) begin
      cmd_valid <= 1'b1;
      row       <= ROW_FIRST;
    end else if (s0_go) begin
      if (row == ROW_LAST) begin
        cmd_valid <= 1'b0;
      end else begin
        row <= row + row_idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      kind    <= s_tuser;
      param_x <= elem_t'(s_tdata[ELEM_W-1:0]);
      param_y <= elem_t'(s_tdata[2*ELEM_W-1:ELEM_W]);
      param_z <= elem_t'(s_tdata[3*ELEM_W-1:2*ELEM_W]);
    end
  end

  // Operand selection for the current row
  always_comb begin
    c_x  = coef_t'(param_x);
    c_y  = coef_t'(param_y);
    c_ny = -c_y;
    c_z  = coef_t'(param_z);
    for (int k = 0; k < NUM_COLS; k++) begin
      rd[k] = mat[row][k];
    end
    for (int k = 0; k < NUM_MUL; k++) begin
      mul_a[k] = ELEM_ZERO;
      mul_b[k] = '0;
    end
    unique case (kind)
      KIND_TRANSLATE: begin
        mul_a[0] = rd[3]; mul_b[0] = c_x;
        mul_a[1] = rd[3]; mul_b[1] = c_y;
        mul_a[2] = rd[3]; mul_b[2] = c_z;
      end
      KIND_ZOOM: begin
        mul_a[0] = rd[0]; mul_b[0] = c_x;
        mul_a[1] = rd[1]; mul_b[1] = c_x;
        mul_a[2] = rd[2]; mul_b[2] = c_x;
      end
      KIND_ROT_X: begin
        mul_a[0] = rd[1]; mul_b[0] = c_x;
        mul_a[1] = rd[2]; mul_b[1] = c_ny;
        mul_a[2] = rd[1]; mul_b[2] = c_y;
        mul_a[3] = rd[2]; mul_b[3] = c_x;
      end
      KIND_ROT_Y: begin
        mul_a[0] = rd[0]; mul_b[0] = c_x;
        mul_a[1] = rd[2]; mul_b[1] = c_y;
        mul_a[2] = rd[0]; mul_b[2] = c_ny;
        mul_a[3] = rd[2]; mul_b[3] = c_x;
      end
      KIND_ROT_Z: begin
        mul_a[0] = rd[0]; mul_b[0] = c_x;
        mul_a[1] = rd[1]; mul_b[1] = c_ny;
        mul_a[2] = rd[0]; mul_b[2] = c_y;
        mul_a[3] = rd[1]; mul_b[3] = c_x;
      end
      default: begin
      end
    endcase
    // Exact product, arithmetic shift gives the floor
    for (int k = 0; k < NUM_MUL; k++) begin
      shp[k] = shp_t'((prod_t'(mul_a[k]) * prod_t'(mul_b[k])) >>> FRAC_BITS);
    end
  end

  // Product stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go) begin
      s1_kind <= kind;
      s1_row  <= row;
      for (int k = 0; k < NUM_COLS; k++) begin
        s1_m[k] <= rd[k];
      end
      for (int k = 0; k < NUM_MUL; k++) begin
        s1_p[k] <= shp[k];
      end
    end
  end

  // Sum and saturate
  always_comb begin
    for (int k = 0; k < NUM_COLS; k++) begin
      new_row[k] = s1_m[k];
    end
    unique case (s1_kind)
      KIND_TRANSLATE: begin
        for (int k = 0; k < 3; k++) begin
          new_row[k] = sat_elem(sum_t'(s1_m[k]) + sum_t'(s1_p[k]));
        end
      end
      KIND_ZOOM: begin
        for (int k = 0; k < 3; k++) begin
          new_row[k] = sat_elem(sum_t'(s1_p[k]));
        end
      end
      KIND_ROT_X: begin
        new_row[1] = sat_elem(sum_t'(s1_p[0]) + sum_t'(s1_p[1]));
        new_row[2] = sat_elem(sum_t'(s1_p[2]) + sum_t'(s1_p[3]));
      end
      KIND_ROT_Y: begin
        new_row[0] = sat_elem(sum_t'(s1_p[0]) + sum_t'(s1_p[1]));
        new_row[2] = sat_elem(sum_t'(s1_p[2]) + sum_t'(s1_p[3]));
      end
      KIND_ROT_Z: begin
        new_row[0] = sat_elem(sum_t'(s1_p[0]) + sum_t'(s1_p[1]));
        new_row[1] = sat_elem(sum_t'(s1_p[2]) + sum_t'(s1_p[3]));
      end
      default: begin
      end
    endcase
  end

  // Matrix write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int k = 0; k < NUM_COLS; k++) begin
          mat[r][k] <= (r == k) ? ELEM_ONE : ELEM_ZERO;
        end
      end
    end else if (s1_valid && adv) begin
      for (int k = 0; k < NUM_COLS; k++) begin
        mat[s1_row][k] <= new_row[k];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && adv) begin
      m_tuser <= s1_row;
      m_tlast <= (s1_row == ROW_LAST);
      for (int k = 0; k < NUM_COLS; k++) begin
        out_e[k] <= new_row[k];
      end
    end
  end

  assign m_tdata = {out_e[3], out_e[2], out_e[1], out_e[0]};

  // Checks
  `TMC_ASSERT(a_row_behind, clk, rst, s1_valid && cmd_valid |-> (s1_row + row_idx_t'(1) == row))
  `TMC_ASSERT(a_take_starts_row0, clk, rst, in_take |=> (cmd_valid && (row == ROW_FIRST)))
  `TMC_ASSERT(a_last_flag, clk, rst, m_tvalid |-> (m_tlast == (m_tuser == ROW_LAST)))
  `TMC_ASSERT(a_row_order, clk, rst, m_tvalid && m_tready && !m_tlast |=> (!m_tvalid || (m_tuser == $past(m_tuser) + row_idx_t'(1))))

endmodule

`default_nettype wire
